### rtl/mtkc_pkg.sv
package mtkc_pkg;

  localparam int unsigned KeyWordsDef = 16;
  localparam int unsigned KeyWordsMax = 16;
  localparam int unsigned KeyPairs    = 8;
  localparam int unsigned TwN         = 624;
  localparam int unsigned TwM         = 397;
  localparam int unsigned IdxW        = 10;

  localparam logic [31:0] TwMatrix   = 32'h9908_b0df;
  localparam logic [31:0] SeedBase   = 32'd19650218;
  localparam logic [31:0] MulInit    = 32'd1812433253;
  localparam logic [31:0] MulMix     = 32'd1664525;
  localparam logic [31:0] MulFinal   = 32'd1566083941;
  localparam logic [31:0] SealWord   = 32'h8000_0000;

  localparam logic [IdxW-1:0] IdxLast  = IdxW'(TwN - 1);
  localparam logic [IdxW-1:0] IdxEmpty = IdxW'(TwN);
  localparam logic [IdxW-1:0] IdxWrap  = IdxW'(TwN - TwM);
  localparam logic [IdxW-1:0] IdxM     = IdxW'(TwM);

  localparam logic [2:0] BytesFull = 3'd4;
  localparam logic [2:0] BytesNone = 3'd0;

  localparam int unsigned CfgIdxW = 4;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        first;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

### rtl/mtkc_in_if.sv
interface mtkc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        first;

  modport source (output valid, data_word, byte_count, first, input ready);
  modport sink   (input valid, data_word, byte_count, first, output ready);
endinterface

### rtl/mtkc_out_if.sv
interface mtkc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic [2:0]  result_bytes;

  modport source (output valid, result_word, result_bytes, input ready);
  modport sink   (input valid, result_word, result_bytes, output ready);
endinterface

### rtl/mtkc_front.sv
module mtkc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mtkc_in_if.sink              in_i,
  output mtkc_pkg::q_head_t    head_o,
  input  logic                 pop_i
);

  mtkc_pkg::item_t   q_mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;
  mtkc_pkg::item_t   cls;
  logic              acc, push, pop;

  // classify: saturate count; a word with no bytes and no reseed does nothing
  always_comb begin
    cls.data  = in_i.data_word;
    cls.cnt   = (in_i.byte_count > mtkc_pkg::BytesFull) ? mtkc_pkg::BytesFull
                                                        : in_i.byte_count;
    cls.first = in_i.first;
  end

  assign in_i.ready = (fill_q != 2'd2);
  assign acc   = in_i.valid && in_i.ready;
  assign push  = acc && (cls.first || (cls.cnt != mtkc_pkg::BytesNone));
  assign pop   = pop_i && (fill_q != 2'd0);

  assign head_o.valid = (fill_q != 2'd0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd2) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid) else $error("pop from empty queue");

endmodule

### rtl/mtkc_back.sv
module mtkc_back #(
  parameter int unsigned KEY_WORDS = mtkc_pkg::KeyWordsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [mtkc_pkg::KeyWordsMax-1:0][31:0] key_i,
  input  mtkc_pkg::q_head_t    head_i,
  output logic                 pop_o,
  mtkc_out_if.source           out_o
);

  localparam int unsigned JW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam logic [JW-1:0] JLast = JW'(KEY_WORDS - 1);
  localparam int unsigned IW = mtkc_pkg::IdxW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_INITA = 13'b0000000000010,
    S_INITB = 13'b0000000000100,
    S_MIXA  = 13'b0000000001000,
    S_MIXB  = 13'b0000000010000,
    S_SEAL  = 13'b0000000100000,
    S_DRAW  = 13'b0000001000000,
    S_TWLA  = 13'b0000010000000,
    S_TWLB  = 13'b0000100000000,
    S_TWA   = 13'b0001000000000,
    S_TWB   = 13'b0010000000000,
    S_RD    = 13'b0100000000000,
    S_TMP   = 13'b1000000000000
  } state_e;

  function automatic logic [31:0] fold30(input logic [31:0] x);
    return x ^ (x >> 30);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_e            st_q;
  logic [IW-1:0]     i_q, k_q, idx_q;
  logic [JW-1:0]     j_q;
  logic              ph3_q;
  logic [31:0]       prev_q, mul_q, kj_q, cur_q;
  logic [31:0]       hist_q [4];
  logic [2:0]        hcnt_q;
  mtkc_pkg::item_t   itm_q;
  logic              ov_q;
  logic [31:0]       ow_q;
  logic [2:0]        ob_q;

  // table: one write and two registered reads per cycle
  logic [31:0]       mem [mtkc_pkg::TwN];
  logic [31:0]       rd1_q, rd2_q;
  logic [IW-1:0]     ra1, ra2, wa;
  logic [31:0]       wd;
  logic              we;

  logic              out_free, rd_go;
  logic [31:0]       mix_val, tw_y, tw_val, drawn, res_full, mask;
  logic [IW-1:0]     kk_next;

  assign out_free = !ov_q || out_o.ready;
  assign rd_go    = (hcnt_q != 3'd0) || out_free;
  assign kk_next  = (i_q == mtkc_pkg::IdxLast) ? '0 : i_q + 1'b1;
  assign mix_val  = (rd1_q ^ mul_q) + kj_q;
  assign tw_y     = {cur_q[31], rd1_q[30:0]};
  assign tw_val   = rd2_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtkc_pkg::TwMatrix : 32'd0);
  assign drawn    = temper(rd1_q);
  assign res_full = drawn ^ hist_q[3] ^ hist_q[2] ^ hist_q[1] ^ hist_q[0] ^ itm_q.data;

  always_comb begin
    unique case (itm_q.cnt)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    ra1 = '0;
    ra2 = (i_q < mtkc_pkg::IdxWrap) ? i_q + mtkc_pkg::IdxM : i_q - mtkc_pkg::IdxWrap;
    we  = 1'b0;
    wa  = i_q;
    wd  = mix_val;
    unique case (st_q)
      S_MIXA:  ra1 = i_q;
      S_TWA:   ra1 = kk_next;
      S_RD:    ra1 = idx_q;
      S_INITB: begin
        we = 1'b1;
        wd = mul_q + 32'(i_q);
      end
      S_MIXB:  we = 1'b1;
      S_SEAL: begin
        we = 1'b1;
        wa = '0;
        wd = mtkc_pkg::SealWord;
      end
      S_TWB: begin
        we = 1'b1;
        wd = tw_val;
      end
      default: ra1 = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd1_q <= mem[ra1];
    rd2_q <= mem[ra2];
  end

  assign pop_o = (st_q == S_IDLE) && head_i.valid;

  always_ff @(posedge clk_i) begin
    if (pop_o) itm_q <= head_i.item;
    if (st_q == S_INITA || st_q == S_MIXA) begin
      mul_q <= (st_q == S_INITA) ? fold30(prev_q) * mtkc_pkg::MulInit
             : (ph3_q ? fold30(prev_q) * mtkc_pkg::MulFinal
                      : fold30(prev_q) * mtkc_pkg::MulMix);
      kj_q  <= ph3_q ? 32'd0 - 32'(i_q) : key_i[4'(j_q)] + 32'(j_q);
    end
    if (st_q == S_TWLB || st_q == S_TWB) cur_q <= rd1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      i_q    <= '0;
      k_q    <= '0;
      j_q    <= '0;
      ph3_q  <= 1'b0;
      idx_q  <= '0;
      prev_q <= '0;
      hcnt_q <= '0;
      hist_q <= '{default: '0};
      ov_q   <= 1'b0;
      ow_q   <= '0;
      ob_q   <= '0;
    end else begin
      // result register: loaded on a data draw, emptied when taken
      if (st_q == S_TMP && hcnt_q == 3'd0) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (head_i.valid) begin
            hcnt_q <= '0;
            if (head_i.item.first) begin
              st_q   <= S_INITA;
              i_q    <= IW'(1);
              prev_q <= mtkc_pkg::SeedBase;
            end else begin
              st_q <= S_DRAW;
            end
          end
        end
        S_INITA: st_q <= S_INITB;
        S_INITB: begin
          if (i_q == mtkc_pkg::IdxLast) begin
            i_q    <= IW'(1);
            j_q    <= '0;
            k_q    <= mtkc_pkg::IdxEmpty;
            ph3_q  <= 1'b0;
            prev_q <= mtkc_pkg::SeedBase;
            st_q   <= S_MIXA;
          end else begin
            prev_q <= mul_q + 32'(i_q);
            i_q    <= i_q + 1'b1;
            st_q   <= S_INITA;
          end
        end
        S_MIXA: st_q <= S_MIXB;
        S_MIXB: begin
          prev_q <= mix_val;
          i_q    <= (i_q == mtkc_pkg::IdxLast) ? IW'(1) : i_q + 1'b1;
          if (!ph3_q) j_q <= (j_q == JLast) ? '0 : j_q + 1'b1;
          if (k_q == IW'(1)) begin
            if (!ph3_q) begin
              ph3_q <= 1'b1;
              k_q   <= mtkc_pkg::IdxLast;
              st_q  <= S_MIXA;
            end else begin
              st_q <= S_SEAL;
            end
          end else begin
            k_q  <= k_q - 1'b1;
            st_q <= S_MIXA;
          end
        end
        S_SEAL: begin
          idx_q  <= mtkc_pkg::IdxEmpty;
          hcnt_q <= 3'd4;
          st_q   <= S_DRAW;
        end
        S_DRAW: st_q <= (idx_q >= mtkc_pkg::IdxEmpty) ? S_TWLA : S_RD;
        S_TWLA: st_q <= S_TWLB;
        S_TWLB: begin
          i_q  <= '0;
          st_q <= S_TWA;
        end
        S_TWA: st_q <= S_TWB;
        S_TWB: begin
          if (i_q == mtkc_pkg::IdxLast) begin
            idx_q <= '0;
            st_q  <= S_RD;
          end else begin
            i_q  <= i_q + 1'b1;
            st_q <= S_TWA;
          end
        end
        S_RD: begin
          if (rd_go) begin
            idx_q <= idx_q + 1'b1;
            st_q  <= S_TMP;
          end
        end
        S_TMP: begin
          if (hcnt_q != 3'd0) begin
            hist_q[0] <= hist_q[1];
            hist_q[1] <= hist_q[2];
            hist_q[2] <= hist_q[3];
            hist_q[3] <= drawn;
            hcnt_q    <= hcnt_q - 1'b1;
            st_q <= (hcnt_q == 3'd1 && itm_q.cnt == mtkc_pkg::BytesNone) ? S_IDLE : S_DRAW;
          end else begin
            ow_q <= res_full & mask;
            ob_q <= itm_q.cnt;
            if (itm_q.cnt == mtkc_pkg::BytesFull) begin
              hist_q[0] <= {hist_q[1][14:0], hist_q[1][31:15]};
              hist_q[1] <= {hist_q[2][20:0], hist_q[2][31:21]};
              hist_q[2] <= {hist_q[3][24:0], hist_q[3][31:25]};
              hist_q[3] <= {drawn[12:0], drawn[31:13]};
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.result_word  = ow_q;
  assign out_o.result_bytes = ob_q;

  a_rise_from_tmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q == S_TMP)) else $error("result from wrong state");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= mtkc_pkg::IdxEmpty) else $error("draw index out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_TMP && hcnt_q == 3'd0) |-> out_free) else $error("result overwritten");
  a_hcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= 3'd4) else $error("history count out of range");

endmodule

### rtl/mt_keystream_word_cipher_core.sv
// A plain word passes from the queue through the idle, draw, read and update steps
// of the back sequencer into the result register; a word that finds the table spent
// first runs a twist, one table entry at a time through the single write port. A word
// with first set first reseeds the table (1870 steps, each step bound by one multiply)
// and then makes its four history draws, the first of which pays for a twist. The back
// sequencer takes one word at a time, and its read step waits while the result is held.
// Reset: async active low; clears key registers, history, draw index and control.
module mt_keystream_word_cipher_core #(
  parameter int unsigned KEY_WORDS = mtkc_pkg::KeyWordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mtkc_in_if.sink                      in_i,
  mtkc_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [mtkc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                  cfg_wdata_i
);

  // key registers, two key words per register, low word first
  logic [mtkc_pkg::KeyPairs-1:0][63:0]      key_q;
  logic [mtkc_pkg::KeyWordsMax-1:0][31:0]   key_words;
  mtkc_pkg::q_head_t                        head;
  logic                                     pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i && cfg_idx_i < mtkc_pkg::CfgIdxW'(mtkc_pkg::KeyPairs)) begin
      key_q[3'(cfg_idx_i)] <= cfg_wdata_i;
    end
  end

  // packed pairs already line up as words 0..15
  assign key_words = key_q;

  // front: accepts words, drops empty ones, queues the rest
  mtkc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: reseed sequencer, twist, draw and history, result register
  mtkc_back #(
    .KEY_WORDS (KEY_WORDS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_words),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Key register map: register p holds key words 2p (low) and 2p+1 (high).
  typedef enum logic [mtkc_pkg::CfgIdxW-1:0] {
    KEY_PAIR_0, KEY_PAIR_1, KEY_PAIR_2, KEY_PAIR_3,
    KEY_PAIR_4, KEY_PAIR_5, KEY_PAIR_6, KEY_PAIR_7
  } key_reg_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  bytes;
  } cipher_out_t;

  // A reseed plus a twist is the longest quiet stretch
  // a correct block shows; the watchdog allows several times that.
  localparam int unsigned QuietLimit = 30000;
  // Settle time before key writes and at the end: a word with no result may
  // still be reseeding when the last expected word comes out.
  localparam int unsigned SettleCycles = 10000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [mtkc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  mtkc_in_if  word_in ();
  mtkc_out_if word_out ();

  mt_keystream_word_cipher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (word_in),
    .out_o       (word_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cipher predictor: own copy of keys, generator table, draw index and history
  // ---------------------------------------------------------------------------
  logic [63:0] key_regs [mtkc_pkg::KeyPairs];
  logic [31:0] twister_words [mtkc_pkg::TwN];
  int unsigned draw_idx;
  logic [31:0] hist [4];

  cipher_out_t expected_q [$];
  int unsigned mismatches;
  bit calm;  // no idling on either side while set

  function automatic logic [31:0] key_word(int unsigned j);
    logic [63:0] pair;
    pair = key_regs[(j >> 1) & 7];
    return j[0] ? pair[63:32] : pair[31:0];
  endfunction

  // Standard array seeding from the key words.
  function automatic void seed_generator();
    int unsigned i, j, k, kl;
    logic [31:0] prev;
    kl = mtkc_pkg::KeyWordsDef;
    twister_words[0] = mtkc_pkg::SeedBase;
    for (i = 1; i < mtkc_pkg::TwN; i++) begin
      prev = twister_words[i-1];
      twister_words[i] = mtkc_pkg::MulInit * (prev ^ (prev >> 30)) + 32'(i);
    end
    i = 1;
    j = 0;
    for (k = (mtkc_pkg::TwN > kl) ? mtkc_pkg::TwN : kl; k > 0; k--) begin
      prev = twister_words[i-1];
      twister_words[i] = (twister_words[i] ^ ((prev ^ (prev >> 30)) * mtkc_pkg::MulMix))
                         + key_word(j) + 32'(j);
      i++;
      j++;
      if (i >= mtkc_pkg::TwN) begin
        twister_words[0] = twister_words[mtkc_pkg::TwN-1];
        i = 1;
      end
      if (j >= kl) j = 0;
    end
    for (k = mtkc_pkg::TwN - 1; k > 0; k--) begin
      prev = twister_words[i-1];
      twister_words[i] = (twister_words[i] ^ ((prev ^ (prev >> 30)) * mtkc_pkg::MulFinal))
                         - 32'(i);
      i++;
      if (i >= mtkc_pkg::TwN) begin
        twister_words[0] = twister_words[mtkc_pkg::TwN-1];
        i = 1;
      end
    end
    twister_words[0] = mtkc_pkg::SealWord;
    draw_idx = mtkc_pkg::TwN;
  endfunction

  function automatic logic [31:0] draw_keystream();
    logic [31:0] y;
    if (draw_idx >= mtkc_pkg::TwN) begin
      for (int unsigned kk = 0; kk < mtkc_pkg::TwN; kk++) begin
        y = {twister_words[kk][31], twister_words[(kk + 1) % mtkc_pkg::TwN][30:0]};
        twister_words[kk] = twister_words[(kk + mtkc_pkg::TwM) % mtkc_pkg::TwN] ^ (y >> 1)
                            ^ (y[0] ? mtkc_pkg::TwMatrix : 32'h0);
      end
      draw_idx = 0;
    end
    y = twister_words[draw_idx];
    draw_idx++;
    y ^= (y >> 11);
    y ^= (y << 7) & 32'h9d2c_5680;
    y ^= (y << 15) & 32'hefc6_0000;
    y ^= (y >> 18);
    return y;
  endfunction

  // Advance the predictor by one accepted word; queue the word it must produce.
  function automatic void predict_word(logic [31:0] data, logic [2:0] cnt, logic first);
    logic [31:0] w, r;
    logic [2:0] n;
    if (first) begin
      seed_generator();
      for (int h = 0; h < 4; h++) hist[h] = draw_keystream();
    end
    if (cnt == mtkc_pkg::BytesNone) return;  // no draw, no result
    n = (cnt > mtkc_pkg::BytesFull) ? mtkc_pkg::BytesFull : cnt;  // 5..7 act as a full word
    w = draw_keystream();
    r = w ^ hist[3] ^ hist[2] ^ hist[1] ^ hist[0] ^ data;
    if (n == mtkc_pkg::BytesFull) begin
      hist[0] = {hist[1][14:0], hist[1][31:15]};  // ror 15
      hist[1] = {hist[2][20:0], hist[2][31:21]};  // rol 11
      hist[2] = {hist[3][24:0], hist[3][31:25]};  // rol 7
      hist[3] = {w[12:0], w[31:13]};              // ror 13
    end else begin
      // partial tail: draw consumed, history kept, upper bytes zeroed
      r &= (32'h1 << (8 * n)) - 32'h1;
    end
    expected_q.push_back('{word: r, bytes: n});
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [31:0] data, logic [2:0] cnt, logic first);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_in.valid      <= 1'b1;
    word_in.data_word  <= data;
    word_in.byte_count <= cnt;
    word_in.first      <= first;
    do @(posedge clk_i); while (!word_in.ready);
    predict_word(data, cnt, first);
  endtask

  // Key writes happen only with the block idle.
  task automatic load_keys(logic [63:0] pairs [mtkc_pkg::KeyPairs]);
    word_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    for (int p = 0; p < mtkc_pkg::KeyPairs; p++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= key_reg_e'(p);
      cfg_wdata_i <= pairs[p];
      key_regs[p] = pairs[p];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // One message: first word reseeds, full words, an optional partial tail.
  // With noise, some words carry a zero count, an oversized count or a
  // restart in the middle.
  task automatic send_message(int unsigned len, bit noisy, inout int unsigned sent);
    logic [2:0] cnt;
    logic first;
    for (int unsigned n = 0; n < len; n++) begin
      cnt = mtkc_pkg::BytesFull;
      first = (n == 0);
      if (n == len - 1 && $urandom_range(0, 1)) cnt = 3'($urandom_range(1, 4));
      if (noisy && $urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: cnt = mtkc_pkg::BytesNone;
          1: cnt = 3'($urandom_range(5, 7));
          default: first = 1'b1;
        endcase
      end
      push_word(rand_data(), cnt, first);
      if (cnt != mtkc_pkg::BytesNone) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      word_out.ready <= 1'b0;
    end else begin
      word_out.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    cipher_out_t exp_w;
    if (rst_ni && word_out.valid && word_out.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h bytes %0d", word_out.result_word,
                   word_out.result_bytes);
      end else begin
        exp_w = expected_q.pop_front();
        if (word_out.result_word !== exp_w.word ||
            word_out.result_bytes !== exp_w.bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: word exp %h got %h, bytes exp %0d got %0d",
                     exp_w.word, word_out.result_word, exp_w.bytes,
                     word_out.result_bytes);
        end
      end
    end
  end

  // Watchdog: cycles without any word moving on either side.
  int unsigned quiet;
  always @(posedge clk_i) begin
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [63:0] pairs [mtkc_pkg::KeyPairs];
    foreach (pairs[p]) pairs[p] = 64'h0;
    load_keys(pairs);
    calm = 1'b1;
    push_word(32'h0000_0000, mtkc_pkg::BytesFull, 1'b1);
    push_word(32'hffff_ffff, mtkc_pkg::BytesFull, 1'b0);
    push_word(32'ha5a5_a5a5, 3'd1, 1'b0);                 // partial, history held
    push_word(32'h1234_5678, mtkc_pkg::BytesFull, 1'b0);  // continue after partial
    push_word(32'hdead_beef, 3'd2, 1'b0);
    push_word(32'hcafe_f00d, 3'd3, 1'b0);
    push_word(32'h0f0f_0f0f, 3'd5, 1'b0);                 // oversized counts
    push_word(32'hf0f0_f0f0, 3'd6, 1'b0);
    push_word(32'h5555_aaaa, 3'd7, 1'b0);
    push_word(32'h0123_4567, mtkc_pkg::BytesNone, 1'b0);  // dropped, no draw
    push_word(32'h89ab_cdef, mtkc_pkg::BytesNone, 1'b1);  // reseed only
    push_word(32'hffff_ffff, mtkc_pkg::BytesFull, 1'b0);
    push_word(32'h0000_0000, 3'd3, 1'b1);                 // one-word message, partial
    calm = 1'b0;
    push_word(32'h7777_7777, mtkc_pkg::BytesFull, 1'b1);
    push_word(32'h8888_8888, mtkc_pkg::BytesFull, 1'b0);
    push_word(32'h9999_9999, 3'd1, 1'b0);
  endtask

  task automatic test_key_extremes();
    logic [63:0] pairs [mtkc_pkg::KeyPairs];
    foreach (pairs[p]) pairs[p] = 64'hffff_ffff_ffff_ffff;
    load_keys(pairs);
    push_word(32'h0000_0000, mtkc_pkg::BytesFull, 1'b1);
    push_word(32'hffff_ffff, mtkc_pkg::BytesFull, 1'b0);
    push_word(32'h1357_9bdf, 3'd2, 1'b0);
    // alternating extremes across pairs and halves
    foreach (pairs[p]) pairs[p] = p[0] ? 64'hffff_ffff_0000_0000 : 64'h0000_0000_ffff_ffff;
    load_keys(pairs);
    push_word(32'h0000_0000, mtkc_pkg::BytesFull, 1'b1);
    push_word(32'h2468_ace0, 3'd3, 1'b0);
  endtask

  // Random keys per phase; mostly well-formed messages, some noisy ones.
  task automatic test_random_messages();
    logic [63:0] pairs [mtkc_pkg::KeyPairs];
    int unsigned sent, len;
    for (int ph = 0; ph < 8; ph++) begin
      foreach (pairs[p]) pairs[p] = {$urandom(), $urandom()};
      load_keys(pairs);
      calm = (ph == 2);
      sent = 0;
      // a message long enough to force a second twist
      if (ph == 4) send_message(700, 1'b0, sent);
      while (sent < 120) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
        send_message(len, $urandom_range(0, 3) == 0, sent);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = KEY_PAIR_0;
    cfg_wdata_i = 64'h0;
    word_in.valid = 1'b0;
    word_in.data_word = 32'h0;
    word_in.byte_count = mtkc_pkg::BytesNone;
    word_in.first = 1'b0;
    word_out.ready = 1'b0;
    stall_left = 0;
    quiet = 0;
    mismatches = 0;
    calm = 1'b0;
    foreach (key_regs[p]) key_regs[p] = 64'h0;
    foreach (twister_words[i]) twister_words[i] = 32'h0;
    foreach (hist[h]) hist[h] = 32'h0;
    draw_idx = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_key_extremes();
    test_random_messages();

    word_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
